// File: sv/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types and constants of the demo chunk deframer.
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD = 3'd5;

  localparam logic [7:0] VERSION_INLINE_BIT = 8'd5;
  localparam logic [4:0] SIZE_ONE_BYTE      = 5'd30;
  localparam logic [4:0] SIZE_TWO_BYTES     = 5'd31;
  localparam logic [7:0] VERSION_RESET      = 8'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic        keyframe;
    logic        inline_delta;
    logic [31:0] tick_delta;
    logic [15:0] chunk_size;
    logic [7:0]  payload_byte;
    logic        last_byte;
  } result_t;

endpackage

// File: sv/dcd_parser.sv
// ----------------------------------------------------------------------------
// dcd_parser
// Chunk stream parse state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module dcd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       data,
  input  logic [7:0]       version,
  output logic             emit,
  output dcd_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_TICKDELTA = 3'd1,
    PH_SIZE_ONE  = 3'd2,
    PH_SIZE_LO   = 3'd3,
    PH_SIZE_HI   = 3'd4,
    PH_PAYLOAD   = 3'd5
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [1:0]  extra_count, extra_count_next;
  logic [31:0] delta_accum, delta_accum_next;
  logic [15:0] size_accum, size_accum_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [2:0]  held_kind, held_kind_next;
  logic        held_keyframe, held_keyframe_next;

  logic [15:0] fin_size;
  logic [2:0]  fin_kind;
  logic        fin;
  logic [15:0] left_dec;
  logic        tick_inline;
  logic [31:0] tick_value;

  always_comb begin
    parse_phase_next   = parse_phase;
    extra_count_next   = extra_count;
    delta_accum_next   = delta_accum;
    size_accum_next    = size_accum;
    bytes_left_next    = bytes_left;
    held_kind_next     = held_kind;
    held_keyframe_next = held_keyframe;
    emit               = 1'b0;
    res                = '0;
    fin                = 1'b0;
    fin_size           = size_accum;
    fin_kind           = held_kind;
    left_dec           = bytes_left - 16'd1;
    tick_inline        = 1'b0;
    tick_value         = '0;

    case (parse_phase)
      PH_TICKDELTA: begin
        delta_accum_next = {delta_accum[23:0], data};
        if (extra_count == 2'd3) begin
          extra_count_next = 2'd0;
          parse_phase_next = PH_HEADER;
          emit             = 1'b1;
          res.kind         = dcd_pkg::KIND_TICK;
          res.keyframe     = held_keyframe;
          res.tick_delta   = {delta_accum[23:0], data};
        end else begin
          extra_count_next = extra_count + 2'd1;
        end
      end
      PH_SIZE_ONE: begin
        fin      = 1'b1;
        fin_size = {8'd0, data};
      end
      PH_SIZE_LO: begin
        size_accum_next  = {8'd0, data};
        parse_phase_next = PH_SIZE_HI;
      end
      PH_SIZE_HI: begin
        fin      = 1'b1;
        fin_size = {data, size_accum[7:0]};
      end
      PH_PAYLOAD: begin
        bytes_left_next  = left_dec;
        emit             = 1'b1;
        res.kind         = dcd_pkg::KIND_PAYLOAD;
        res.payload_byte = data;
        res.last_byte    = (left_dec == 16'd0);
        if (left_dec == 16'd0) begin
          parse_phase_next = PH_HEADER;
        end
      end
      default: begin
        if (data[7]) begin
          // Version 5 and later mark an inline delta with bit 5.
          if (version >= dcd_pkg::VERSION_INLINE_BIT) begin
            tick_inline = data[5];
            tick_value  = {27'd0, data[4:0]};
          end else begin
            tick_inline = (data[5:0] != 6'd0);
            tick_value  = {26'd0, data[5:0]};
          end
          if (tick_inline) begin
            parse_phase_next = PH_HEADER;
            emit             = 1'b1;
            res.kind         = dcd_pkg::KIND_TICK;
            res.keyframe     = data[6];
            res.inline_delta = 1'b1;
            res.tick_delta   = tick_value;
          end else begin
            held_keyframe_next = data[6];
            delta_accum_next   = '0;
            extra_count_next   = 2'd0;
            parse_phase_next   = PH_TICKDELTA;
          end
        end else begin
          fin_kind       = (data[6:5] == 2'd0) ? dcd_pkg::KIND_UNKNOWN : {1'b0, data[6:5]};
          held_kind_next = fin_kind;
          if (data[4:0] == dcd_pkg::SIZE_ONE_BYTE) begin
            parse_phase_next = PH_SIZE_ONE;
          end else if (data[4:0] == dcd_pkg::SIZE_TWO_BYTES) begin
            parse_phase_next = PH_SIZE_LO;
          end else begin
            fin      = 1'b1;
            fin_size = {11'd0, data[4:0]};
          end
        end
      end
    endcase

    // The chunk size is complete: emit the descriptor and choose what follows.
    if (fin) begin
      size_accum_next = fin_size;
      emit            = 1'b1;
      res.kind        = fin_kind;
      res.chunk_size  = fin_size;
      if (fin_kind == dcd_pkg::KIND_UNKNOWN || fin_size == 16'd0) begin
        parse_phase_next = PH_HEADER;
      end else begin
        bytes_left_next  = fin_size;
        parse_phase_next = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_HEADER;
      extra_count   <= '0;
      delta_accum   <= '0;
      size_accum    <= '0;
      bytes_left    <= '0;
      held_kind     <= '0;
      held_keyframe <= 1'b0;
    end else if (go) begin
      parse_phase   <= parse_phase_next;
      extra_count   <= extra_count_next;
      delta_accum   <= delta_accum_next;
      size_accum    <= size_accum_next;
      bytes_left    <= bytes_left_next;
      held_kind     <= held_kind_next;
      held_keyframe <= held_keyframe_next;
    end
  end

endmodule

// File: sv/dcd_out_reg.sv
// ----------------------------------------------------------------------------
// dcd_out_reg
// Result register with valid and ready toward the consumer.
// ----------------------------------------------------------------------------
module dcd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dcd_pkg::result_t load_res,
  output logic             space,
  output logic             res_valid,
  input  logic             res_ready,
  output dcd_pkg::result_t res
);

  // The register can take a new item in the same cycle the held one leaves.
  assign space = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (space) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      res <= load_res;
    end
  end

endmodule

// File: sv/demo_chunk_deframer.sv
// ----------------------------------------------------------------------------
// demo_chunk_deframer
// Splits a recorded-demo chunk byte stream into descriptors and payload items.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle with no bubbles while the result
// side is ready. A byte is held in the input register, then the parse logic
// updates the chunk state and, when the byte completes a header or carries
// payload, writes one item into the result register. Bytes that only continue
// a header (tick delta or size bytes) produce no item. Backpressure on the
// result side stalls the input register and, through it, the stream. The
// format version register may be written at any time the block is idle and
// is read when a tick header is parsed.
module demo_chunk_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_ready,
  input  logic [7:0]  stream_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  format_version,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic        keyframe,
  output logic        inline_delta,
  output logic [31:0] tick_delta,
  output logic [15:0] chunk_size,
  output logic [7:0]  payload_byte,
  output logic        last_byte
);

  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic [7:0]       version;
  logic             space;
  logic             go;
  logic             emit;
  dcd_pkg::result_t parse_res;
  dcd_pkg::result_t out_res;

  assign cfg_ready    = 1'b1;
  assign go           = hold_valid && space;
  assign stream_ready = !hold_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      version <= dcd_pkg::VERSION_RESET;
    end else if (cfg_valid) begin
      version <= format_version;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (stream_ready) begin
      hold_valid <= stream_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream_ready && stream_valid) begin
      hold_byte <= stream_byte;
    end
  end

  dcd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .data    (hold_byte),
    .version (version),
    .emit    (emit),
    .res     (parse_res)
  );

  dcd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (go && emit),
    .load_res  (parse_res),
    .space     (space),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (out_res)
  );

  assign kind         = out_res.kind;
  assign keyframe     = out_res.keyframe;
  assign inline_delta = out_res.inline_delta;
  assign tick_delta   = out_res.tick_delta;
  assign chunk_size   = out_res.chunk_size;
  assign payload_byte = out_res.payload_byte;
  assign last_byte    = out_res.last_byte;

endmodule
